// ===== hw/rtl/cat_pkg.sv =====
package cat_pkg;

   localparam int PHASE_BITS  = 32;
   localparam int ACCEL_WIDTH = 24;

   localparam int RADIUS_BITS = 20;
   localparam int RAD_BITS    = RADIUS_BITS + 1;
   localparam int FRAC_SHIFT  = 28;
   localparam int DIV_BITS    = ACCEL_WIDTH - 1 + FRAC_SHIFT;
   localparam int SQ_BITS     = DIV_BITS + (DIV_BITS % 2);
   localparam int ROOT_BITS   = SQ_BITS / 2;
   localparam int SREM_BITS   = ROOT_BITS + 2;
   localparam int CNT_BITS    = $clog2(SQ_BITS + 1);

   localparam int SPEED_BITS  = 24;
   localparam int SUM_BITS    = ROOT_BITS + 1;
   localparam int CMP_BITS    = (SUM_BITS > SPEED_BITS) ? SUM_BITS : SPEED_BITS;
   localparam int TIME_BITS   = 32;
   localparam int HEAD_BITS   = 16;

   localparam int X_BITS      = SPEED_BITS + TIME_BITS;
   localparam int X_HALF      = (X_BITS + 1) / 2;
   localparam int TS_BITS     = 42;
   localparam int TS_HALF     = (TS_BITS + 1) / 2;
   localparam int PP_BITS     = X_HALF + TS_HALF;
   localparam int PROD_BITS   = 64;

   localparam logic [TS_BITS-1:0]    TURN_SCALE = 42'd2867080569611;
   localparam logic [SPEED_BITS-1:0] SPEED_MAX  = {SPEED_BITS{1'b1}};

   localparam int CSR_IDX_BITS = 2;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_KNOWN_RADIUS = 2'd0,
      CSR_EXTRA_RADIUS = 2'd1,
      CSR_DUAL_MODE    = 2'd2,
      CSR_UNUSED       = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      LANE_IDLE,
      LANE_DIV,
      LANE_ROOT
   } lane_state_type;

   typedef enum logic [2:0] {
      MRG_IDLE,
      MRG_PROD,
      MRG_PART,
      MRG_PHASE,
      MRG_DONE
   } merge_state_type;

   typedef enum logic [1:0] {
      TOP_IDLE,
      TOP_LANES,
      TOP_MERGE,
      TOP_HOLD
   } top_state_type;

   typedef struct packed {
      logic                 done;
      logic [ROOT_BITS-1:0] root;
   } lane_out_type;

   typedef struct packed {
      logic                 start;
      logic                 dual;
      logic                 kill;
      logic [TIME_BITS-1:0] dt;
   } merge_ctl_type;

endpackage

// ===== hw/rtl/cat_if.sv =====
interface cat_req_if;
   import cat_pkg::*;
   logic                          valid;
   logic                          ready;
   logic signed [ACCEL_WIDTH-1:0] accel_first;
   logic signed [ACCEL_WIDTH-1:0] accel_second;
   logic [TIME_BITS-1:0]          now_ms;
   modport source (output valid, accel_first, accel_second, now_ms, input ready);
   modport sink   (input valid, accel_first, accel_second, now_ms, output ready);
endinterface

interface cat_rsp_if;
   import cat_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [HEAD_BITS-1:0]  heading;
   logic [SPEED_BITS-1:0] angular_speed;
   modport source (output valid, heading, angular_speed, input ready);
   modport sink   (input valid, heading, angular_speed, output ready);
endinterface

interface cat_csr_if;
   import cat_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CSR_IDX_BITS-1:0] index;
   logic [RADIUS_BITS-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/cat_lane.sv =====
module cat_lane (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic signed [cat_pkg::ACCEL_WIDTH-1:0]  accel,
   input  logic [cat_pkg::RAD_BITS-1:0]            radius,
   output cat_pkg::lane_out_type                   result
);
   import cat_pkg::*;

   lane_state_type         state_ff, state_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [SQ_BITS-1:0]     num_ff, num_in;
   logic [RAD_BITS-1:0]    rem_ff, rem_in;
   logic [RAD_BITS-1:0]    rad_ff, rad_in;
   logic [SREM_BITS-1:0]   sr_ff, sr_in;
   logic [ROOT_BITS-1:0]   root_ff, root_in;
   logic                   zero_ff, zero_in;
   logic                   done_ff, done_in;

   logic [RAD_BITS:0]      div_t, div_d;
   logic                   div_ge;
   logic [SREM_BITS-1:0]   sq_cur, sq_trial;
   logic                   sq_ge;

   always_comb begin
      div_t    = {rem_ff, num_ff[SQ_BITS-1]};
      div_ge   = div_t >= {1'b0, rad_ff};
      div_d    = div_t - {1'b0, rad_ff};
      sq_cur   = {sr_ff[SREM_BITS-3:0], num_ff[SQ_BITS-1 -: 2]};
      sq_trial = {root_ff, 2'b01};
      sq_ge    = sq_cur >= sq_trial;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         LANE_IDLE: begin
            if (start) state_in = LANE_DIV;
         end
         LANE_DIV: begin
            if (cnt_ff == '0) state_in = LANE_ROOT;
         end
         LANE_ROOT: begin
            if (cnt_ff == '0) state_in = LANE_IDLE;
         end
         default: state_in = LANE_IDLE;
      endcase
   end

   always_comb begin
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      rad_in  = rad_ff;
      sr_in   = sr_ff;
      root_in = root_ff;
      zero_in = zero_ff;
      done_in = 1'b0;
      unique case (state_ff)
         LANE_IDLE: begin
            if (start) begin
               num_in  = SQ_BITS'(accel[ACCEL_WIDTH-2:0]) << FRAC_SHIFT;
               rem_in  = '0;
               rad_in  = radius;
               zero_in = (radius == '0) || accel[ACCEL_WIDTH-1] || (accel == '0);
               cnt_in  = CNT_BITS'(SQ_BITS - 1);
               sr_in   = '0;
               root_in = '0;
            end
         end
         LANE_DIV: begin
            rem_in = div_ge ? div_d[RAD_BITS-1:0] : div_t[RAD_BITS-1:0];
            num_in = {num_ff[SQ_BITS-2:0], div_ge};
            cnt_in = (cnt_ff == '0) ? CNT_BITS'(ROOT_BITS - 1) : cnt_ff - 1'b1;
         end
         LANE_ROOT: begin
            sr_in   = sq_ge ? sq_cur - sq_trial : sq_cur;
            root_in = {root_ff[ROOT_BITS-2:0], sq_ge};
            num_in  = {num_ff[SQ_BITS-3:0], 2'b00};
            cnt_in  = cnt_ff - 1'b1;
            done_in = (cnt_ff == '0);
         end
         default: begin
            done_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LANE_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      rad_ff  <= rad_in;
      sr_ff   <= sr_in;
      root_ff <= root_in;
      zero_ff <= zero_in;
   end

   assign result.done = done_ff;
   assign result.root = zero_ff ? '0 : root_ff;

endmodule

// ===== hw/rtl/cat_merge.sv =====
module cat_merge (
   input  logic                              clock,
   input  logic                              reset,
   input  cat_pkg::merge_ctl_type            ctl,
   input  cat_pkg::lane_out_type             lane_first,
   input  cat_pkg::lane_out_type             lane_second,
   output logic [cat_pkg::HEAD_BITS-1:0]     heading,
   output logic [cat_pkg::SPEED_BITS-1:0]    speed,
   output logic                              done
);
   import cat_pkg::*;

   merge_state_type        state_ff, state_in;
   logic [1:0]             part_ff, part_in;
   logic [SPEED_BITS-1:0]  speed_ff, speed_in;
   logic [X_BITS-1:0]      x_ff, x_in;
   logic [PROD_BITS-1:0]   acc_ff, acc_in;
   logic [PHASE_BITS-1:0]  phase_ff, phase_in;

   logic [CMP_BITS-1:0]    sum;
   logic [SPEED_BITS-1:0]  sat;
   logic [X_HALF-1:0]      x_sel;
   logic [TS_HALF-1:0]     t_sel;
   logic [PP_BITS-1:0]     pp;
   logic [PROD_BITS-1:0]   pp_wide, pp_shift;

   always_comb begin
      if (ctl.dual) begin
         sum = CMP_BITS'((SUM_BITS'(lane_first.root) + SUM_BITS'(lane_second.root)) >> 1);
      end else begin
         sum = CMP_BITS'(lane_first.root);
      end
      if (ctl.kill) begin
         sat = '0;
      end else if (sum > CMP_BITS'(SPEED_MAX)) begin
         sat = SPEED_MAX;
      end else begin
         sat = sum[SPEED_BITS-1:0];
      end
   end

   always_comb begin
      x_sel   = part_ff[1] ? X_HALF'(x_ff[X_BITS-1:X_HALF]) : x_ff[X_HALF-1:0];
      t_sel   = part_ff[0] ? TS_HALF'(TURN_SCALE[TS_BITS-1:TS_HALF])
                           : TURN_SCALE[TS_HALF-1:0];
      pp      = PP_BITS'(x_sel) * PP_BITS'(t_sel);
      pp_wide = PROD_BITS'(pp);
      unique case (part_ff)
         2'd0:    pp_shift = pp_wide;
         2'd1:    pp_shift = pp_wide << TS_HALF;
         2'd2:    pp_shift = pp_wide << X_HALF;
         default: pp_shift = pp_wide << (X_HALF + TS_HALF);
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         MRG_IDLE:  if (ctl.start) state_in = MRG_PROD;
         MRG_PROD:  state_in = MRG_PART;
         MRG_PART:  if (part_ff == 2'd3) state_in = MRG_PHASE;
         MRG_PHASE: state_in = MRG_DONE;
         MRG_DONE:  state_in = MRG_IDLE;
         default:   state_in = MRG_IDLE;
      endcase
   end

   always_comb begin
      part_in  = part_ff;
      speed_in = speed_ff;
      x_in     = x_ff;
      acc_in   = acc_ff;
      phase_in = phase_ff;
      unique case (state_ff)
         MRG_IDLE: begin
            if (ctl.start) speed_in = sat;
         end
         MRG_PROD: begin
            x_in    = X_BITS'(speed_ff) * X_BITS'(ctl.dt);
            acc_in  = '0;
            part_in = 2'd0;
         end
         MRG_PART: begin
            acc_in  = acc_ff + pp_shift;
            part_in = part_ff + 2'd1;
         end
         MRG_PHASE: begin
            phase_in = phase_ff + acc_ff[PROD_BITS-1 -: PHASE_BITS];
         end
         default: begin
            part_in = part_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MRG_IDLE;
         phase_ff <= '0;
         speed_ff <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         speed_ff <= speed_in;
      end
      part_ff <= part_in;
      x_ff    <= x_in;
      acc_ff  <= acc_in;
   end

   assign heading = phase_ff[PHASE_BITS-1 -: HEAD_BITS];
   assign speed   = speed_ff;
   assign done    = (state_ff == MRG_DONE);

endmodule

// ===== hw/rtl/centripetal_angle_tracker.sv =====
// Channel  Dir  Fields                                        Word accepted when
// req_if   in   accel_first, accel_second, now_ms             valid && ready
// rsp_if   out  heading, angular_speed                        valid && ready
// csr_if   in   index, data                                   valid (ready always high)
//
// Once a word is accepted, the two lanes divide bit by bit, take the square root two bits
// a cycle and flag completion; the merge stage then multiplies the speed by the time step,
// sums four partial products and updates the phase. No word is taken before the previous
// one is through. A new word is taken only while idle, which may be while the previous
// result still waits in the output register; if the next result is finished before that one
// is read, it is held in the merge stage and no word is taken until the output frees up.
// Reset clears the registers, the phase, the previous time and the result valid flag.
module centripetal_angle_tracker (
   input  logic       clock,
   input  logic       reset,
   cat_req_if.sink    req_if,
   cat_rsp_if.source  rsp_if,
   cat_csr_if.sink    csr_if
);
   import cat_pkg::*;

   top_state_type           state_ff, state_in;
   logic [RADIUS_BITS-1:0]  known_ff, known_in;
   logic [RADIUS_BITS-1:0]  extra_ff, extra_in;
   logic                    dual_ff, dual_in;
   logic [TIME_BITS-1:0]    prev_ff, prev_in;
   logic                    tvalid_ff, tvalid_in;
   logic [TIME_BITS-1:0]    dt_ff, dt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [HEAD_BITS-1:0]    head_ff, head_in;
   logic [SPEED_BITS-1:0]   spd_ff, spd_in;

   logic                    accept, out_free, load_out;
   logic signed [RAD_BITS:0] r2;
   logic                    kill;
   merge_ctl_type           mctl;
   lane_out_type            lane_first, lane_second;
   logic [HEAD_BITS-1:0]    m_heading;
   logic [SPEED_BITS-1:0]   m_speed;
   logic                    m_done;

   assign accept   = req_if.valid && req_if.ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      r2   = $signed({2'b00, known_ff}) + (RAD_BITS + 1)'($signed(extra_ff));
      kill = (known_ff == '0) || (dual_ff && (r2[RAD_BITS] || (r2 == '0)));
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         TOP_IDLE:  if (accept) state_in = TOP_LANES;
         TOP_LANES: if (lane_first.done) state_in = TOP_MERGE;
         TOP_MERGE: if (m_done) state_in = out_free ? TOP_IDLE : TOP_HOLD;
         TOP_HOLD:  if (out_free) state_in = TOP_IDLE;
         default:   state_in = TOP_IDLE;
      endcase
   end

   always_comb begin
      req_if.ready = (state_ff == TOP_IDLE);
      load_out     = ((state_ff == TOP_MERGE) && m_done && out_free)
                     || ((state_ff == TOP_HOLD) && out_free);
      mctl.start   = (state_ff == TOP_LANES) && lane_first.done;
      mctl.dual    = dual_ff;
      mctl.kill    = kill;
      mctl.dt      = dt_ff;
   end

   always_comb begin
      known_in = known_ff;
      extra_in = extra_ff;
      dual_in  = dual_ff;
      if (csr_if.valid) begin
         unique case (csr_index_type'(csr_if.index))
            CSR_KNOWN_RADIUS: known_in = csr_if.data;
            CSR_EXTRA_RADIUS: extra_in = csr_if.data;
            CSR_DUAL_MODE:    dual_in  = csr_if.data[0];
            default:          dual_in  = dual_ff;
         endcase
      end
   end

   always_comb begin
      prev_in   = prev_ff;
      tvalid_in = tvalid_ff;
      dt_in     = dt_ff;
      if (accept) begin
         prev_in   = req_if.now_ms;
         tvalid_in = 1'b1;
         dt_in     = tvalid_ff ? req_if.now_ms - prev_ff : '0;
      end
      head_in      = load_out ? m_heading : head_ff;
      spd_in       = load_out ? m_speed : spd_ff;
      rsp_valid_in = load_out ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TOP_IDLE;
         known_ff     <= '0;
         extra_ff     <= '0;
         dual_ff      <= 1'b0;
         prev_ff      <= '0;
         tvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         known_ff     <= known_in;
         extra_ff     <= extra_in;
         dual_ff      <= dual_in;
         prev_ff      <= prev_in;
         tvalid_ff    <= tvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dt_ff   <= dt_in;
      head_ff <= head_in;
      spd_ff  <= spd_in;
   end

   assign csr_if.ready        = 1'b1;
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.heading       = head_ff;
   assign rsp_if.angular_speed = spd_ff;

   cat_lane u_lane_first (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .accel  (req_if.accel_first),
      .radius ({1'b0, known_ff}),
      .result (lane_first)
   );

   cat_lane u_lane_second (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .accel  (req_if.accel_second),
      .radius (r2[RAD_BITS-1:0]),
      .result (lane_second)
   );

   cat_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .ctl         (mctl),
      .lane_first  (lane_first),
      .lane_second (lane_second),
      .heading     (m_heading),
      .speed       (m_speed),
      .done        (m_done)
   );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import cat_pkg::*;

   localparam int WATCHDOG_LIMIT = 40000;
   localparam int DRAIN_CYCLES   = 100;
   localparam int DIRECTED_ROWS  = 18;
   localparam int HOLD_CYCLES    = 1500;

   typedef struct {
      logic [HEAD_BITS-1:0]  heading;
      logic [SPEED_BITS-1:0] speed;
   } reading_type;

   typedef struct {
      logic [RADIUS_BITS-1:0]        radius;
      logic signed [RADIUS_BITS-1:0] extra;
      logic                          dual;
      logic signed [ACCEL_WIDTH-1:0] a1;
      logic signed [ACCEL_WIDTH-1:0] a2;
      logic [TIME_BITS-1:0]          t;
      logic                          typed;
      logic [SPEED_BITS-1:0]         speed;
   } directed_row_type;

   logic clock;
   logic reset;

   cat_req_if req_if ();
   cat_rsp_if rsp_if ();
   cat_csr_if csr_if ();

   centripetal_angle_tracker dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // Predictor state and its copy of the registers.
   logic [RADIUS_BITS-1:0]        radius_reg;
   logic signed [RADIUS_BITS-1:0] extra_reg;
   logic                          dual_reg;
   logic [PHASE_BITS-1:0]         phase_acc;
   logic [TIME_BITS-1:0]          last_time;
   logic                          have_time;

   reading_type      expected_readings[$];
   directed_row_type directed_rows[DIRECTED_ROWS];
   int               error_count = 0;
   int               quiet_cycles = 0;
   int               hold_left = 0;
   logic             hold_request = 1'b0;
   logic             hold_taken = 1'b0;
   int               stall_pct;
   int               idle_pct;
   logic [TIME_BITS-1:0] clock_ms;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [63:0] root_floor(logic [63:0] x);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= x) begin
            root = trial;
         end
      end
      return root;
   endfunction

   function automatic logic [63:0] lane_speed(logic signed [ACCEL_WIDTH-1:0] a,
                                              logic [63:0] r);
      logic [63:0] num;
      if (r == '0 || a <= 0) begin
         return '0;
      end
      num = 64'(a) << FRAC_SHIFT;
      return root_floor(num / r);
   endfunction

   function automatic logic [SPEED_BITS-1:0] predict_speed(
         logic signed [ACCEL_WIDTH-1:0] a1, logic signed [ACCEL_WIDTH-1:0] a2);
      logic signed [63:0] r2;
      logic [63:0] s;
      if (radius_reg == '0) begin
         return '0;
      end
      if (!dual_reg) begin
         s = lane_speed(a1, 64'(radius_reg));
      end else begin
         r2 = $signed({44'd0, radius_reg}) + 64'(extra_reg);
         if (r2 <= 0) begin
            return '0;
         end
         s = (lane_speed(a1, 64'(radius_reg)) + lane_speed(a2, r2)) >> 1;
      end
      return (s > 64'(SPEED_MAX)) ? SPEED_MAX : s[SPEED_BITS-1:0];
   endfunction

   function automatic reading_type advance_heading(logic signed [ACCEL_WIDTH-1:0] a1,
                                                   logic signed [ACCEL_WIDTH-1:0] a2,
                                                   logic [TIME_BITS-1:0] t);
      reading_type r;
      logic [TIME_BITS-1:0] dt;
      logic [127:0] prod;
      dt = have_time ? t - last_time : '0;
      last_time = t;
      have_time = 1'b1;
      r.speed = predict_speed(a1, a2);
      prod = 128'(r.speed) * 128'(dt) * 128'(TURN_SCALE);
      phase_acc = phase_acc + prod[63:32];
      r.heading = phase_acc[PHASE_BITS-1 -: HEAD_BITS];
      return r;
   endfunction

   task automatic drain();
      while (expected_readings.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, logic [RADIUS_BITS-1:0] data);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      case (idx)
         CSR_KNOWN_RADIUS: radius_reg = data;
         CSR_EXTRA_RADIUS: extra_reg  = data;
         CSR_DUAL_MODE:    dual_reg   = data[0];
         default: ;
      endcase
   endtask

   task automatic set_geometry(logic [RADIUS_BITS-1:0] k, logic [RADIUS_BITS-1:0] e,
                               logic d);
      drain();
      csr_write(CSR_KNOWN_RADIUS, k);
      csr_write(CSR_EXTRA_RADIUS, e);
      csr_write(CSR_DUAL_MODE, {19'($urandom_range(0, 524287)), d});
      csr_write(CSR_UNUSED, RADIUS_BITS'($urandom));
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic send_sample(logic signed [ACCEL_WIDTH-1:0] a1,
                              logic signed [ACCEL_WIDTH-1:0] a2,
                              logic [TIME_BITS-1:0] t, logic typed,
                              logic [SPEED_BITS-1:0] typed_speed);
      reading_type r;
      while ($urandom_range(0, 99) < idle_pct) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
      @(negedge clock);
      req_if.valid        <= 1'b1;
      req_if.accel_first  <= a1;
      req_if.accel_second <= a2;
      req_if.now_ms       <= t;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      r = advance_heading(a1, a2, t);
      if (typed) begin
         r.speed = typed_speed;
      end
      expected_readings.push_back(r);
   endtask

   task automatic release_input();
      @(negedge clock);
      req_if.valid <= 1'b0;
   endtask

   function automatic logic signed [ACCEL_WIDTH-1:0] pick_accel();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return ACCEL_WIDTH'($urandom_range(1, 200000));
         6: return ACCEL_WIDTH'($urandom);
         7: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
         8: return -$signed(24'($urandom_range(0, 1000)));
         default: return ACCEL_WIDTH'($urandom_range(4000000, 8388607));
      endcase
   endfunction

   function automatic logic [TIME_BITS-1:0] next_time();
      if ($urandom_range(0, 19) == 0) begin
         clock_ms = $urandom;
      end else begin
         clock_ms = clock_ms + $urandom_range(0, 40);
      end
      return clock_ms;
   endfunction

   task automatic random_geometry();
      logic [RADIUS_BITS-1:0] k;
      logic [RADIUS_BITS-1:0] e;
      case ($urandom_range(0, 5))
         0: k = 20'd1;
         1: k = 20'hFFFFF;
         2: k = '0;
         3: k = 20'd65536;
         default: k = RADIUS_BITS'($urandom_range(1, 1048575));
      endcase
      case ($urandom_range(0, 4))
         0: e = 20'h80000;
         1: e = 20'h7FFFF;
         2: e = -k;
         default: e = RADIUS_BITS'($urandom);
      endcase
      set_geometry(k, e, 1'($urandom_range(0, 1)));
   endtask

   // Receiver: random stalls, or a long hold-off when one is requested.
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_request && !hold_taken) begin
         rsp_if.ready <= 1'b0;
         hold_taken   <= 1'b1;
         hold_left    <= HOLD_CYCLES - 1;
      end else if (hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      reading_type exp_r;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_readings.size() == 0) begin
            $error("unexpected word: heading %0d angular_speed %0d",
                   rsp_if.heading, rsp_if.angular_speed);
            error_count++;
         end else begin
            exp_r = expected_readings.pop_front();
            if (rsp_if.heading !== exp_r.heading) begin
               $error("heading: expected %0d, got %0d", exp_r.heading, rsp_if.heading);
               error_count++;
            end
            if (rsp_if.angular_speed !== exp_r.speed) begin
               $error("angular_speed: expected %0d, got %0d", exp_r.speed,
                      rsp_if.angular_speed);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      directed_row_type row;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.accel_first = '0;
      req_if.accel_second = '0;
      req_if.now_ms = '0;
      csr_if.valid = 1'b0;
      csr_if.index = CSR_KNOWN_RADIUS;
      csr_if.data = '0;
      stall_pct = 0;
      idle_pct = 0;
      clock_ms = '0;
      radius_reg = '0;
      extra_reg = '0;
      dual_reg = 1'b0;
      phase_acc = '0;
      last_time = '0;
      have_time = 1'b0;

      directed_rows = '{
         '{20'd0,     20'sd0,      1'b0, 24'sd256,    24'sd0,      32'd100,  1'b1, 24'd0},
         '{20'd65536, 20'sd0,      1'b0, 24'sd0,      24'sd0,      32'd110,  1'b1, 24'd0},
         '{20'd65536, 20'sd0,      1'b0, 24'sh800000, 24'sd0,      32'd120,  1'b1, 24'd0},
         '{20'd65536, 20'sd0,      1'b0, 24'sd256,    24'sd0,      32'd130,  1'b1, 24'd1024},
         '{20'd65536, 20'sd0,      1'b0, 24'sh7FFFFF, 24'sh7FFFFF, 32'd131,  1'b0, 24'd0},
         '{20'd65536, 20'sd0,      1'b0, 24'sd1,      24'sd0,      32'hFFFFFFF0, 1'b0, 24'd0},
         '{20'd65536, 20'sd0,      1'b0, 24'sd1024,   24'sd0,      32'd5,    1'b1, 24'd2048},
         '{20'd1,     20'sd0,      1'b0, 24'sh7FFFFF, 24'sd0,      32'd20,   1'b1, SPEED_MAX},
         '{20'd1,     20'sd0,      1'b0, 24'sd1,      24'sd0,      32'd4000, 1'b1, 24'd16384},
         '{20'hFFFFF, 20'sh80000,  1'b1, 24'sd256,    24'sd256,    32'd4010, 1'b0, 24'd0},
         '{20'hFFFFF, 20'sh80000,  1'b1, -24'sd1,     24'sh7FFFFF, 32'd4020, 1'b0, 24'd0},
         '{20'hFFFFF, 20'sh80000,  1'b1, 24'sh7FFFFF, 24'sh800000, 32'd4021, 1'b0, 24'd0},
         '{20'd65536, -20'sd65536, 1'b1, 24'sd256,    24'sd256,    32'd4030, 1'b1, 24'd0},
         '{20'd65536, 20'sh7FFFF,  1'b1, 24'sd256,    24'sd0,      32'd4040, 1'b1, 24'd512},
         '{20'd65536, 20'sh7FFFF,  1'b1, 24'sd0,      24'sh7FFFFF, 32'd4050, 1'b0, 24'd0},
         '{20'd0,     20'sd5,      1'b1, 24'sd256,    24'sd256,    32'd4060, 1'b1, 24'd0},
         '{20'd1,     20'sd0,      1'b1, 24'sh7FFFFF, 24'sh7FFFFF, 32'd4070, 1'b1, SPEED_MAX},
         '{20'd1,     20'sd0,      1'b1, 24'sd100,    24'sd100,    32'hFFFFFFFF, 1'b0, 24'd0}
      };

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row = directed_rows[i];
         if (i > 0 && (row.radius != radius_reg || row.extra != extra_reg
                       || row.dual != dual_reg)) begin
            release_input();
            set_geometry(row.radius, row.extra, row.dual);
         end
         send_sample(row.a1, row.a2, row.t, row.typed, row.speed);
      end
      release_input();
      clock_ms = 32'hFFFFFFFF;

      // The receiver holds off while words keep coming, so the input stalls.
      set_geometry(20'd65536, 20'sd100, 1'b1);
      hold_request = 1'b1;
      for (int i = 0; i < 10; i++) begin
         send_sample(pick_accel(), pick_accel(), next_time(), 1'b0, '0);
      end
      release_input();
      drain();

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 62; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 62; end
            default: begin idle_pct = 37; stall_pct = 37; end
         endcase
         for (int s = 0; s < 2; s++) begin
            random_geometry();
            for (int i = 0; i < 85; i++) begin
               send_sample(pick_accel(), pick_accel(), next_time(), 1'b0, '0);
            end
            release_input();
         end
      end

      stall_pct = 0;
      drain();
      if (error_count == 0 && expected_readings.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/cat_pkg.sv
hw/rtl/cat_if.sv
hw/rtl/cat_lane.sv
hw/rtl/cat_merge.sv
hw/rtl/centripetal_angle_tracker.sv
tb/testbench.sv
